>>> hdl/htc_pkg.sv
// shared types, constants and helpers of the homogeneous triangle clipper
`timescale 1ns / 1ps
package htc_pkg;

	localparam int CW = 32;
	localparam int DW = CW + 1;
	localparam int FW = CW + 2;
	localparam int WF = 62 - CW;
	localparam int QW = WF + 1;
	localparam int PW = DW + QW;
	localparam int NUM_PLANES = 6;
	localparam int PLW = 3;
	localparam int QDEPTH = 2;

	localparam logic REG_NEAR = 1'b0;
	localparam logic REG_FAR  = 1'b1;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} vertex_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t a_w;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t b_w;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
		coord_t c_w;
	} tri_in_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		coord_t out_w;
		logic   is_last;
		logic   is_empty;
	} vert_out_t;

	typedef struct packed {
		vertex_t a;
		vertex_t b;
		vertex_t c;
		logic    pass;
	} tri_word_t;

	function automatic coord_t vcoord(vertex_t v, logic [1:0] k);
		coord_t r;
		case (k)
			2'd0: r = v.x;
			2'd1: r = v.y;
			2'd2: r = v.z;
			default: r = v.w;
		endcase
		return r;
	endfunction

	function automatic vert_out_t to_out(vertex_t v, logic last);
		vert_out_t o;
		o.out_x = v.x;
		o.out_y = v.y;
		o.out_z = v.z;
		o.out_w = v.w;
		o.is_last = last;
		o.is_empty = 1'b0;
		return o;
	endfunction

endpackage

>>> hdl/htc_front.sv
// front end: limit registers, view-volume test and hand-off of each triangle
`timescale 1ns / 1ps
module htc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  htc_pkg::coord_t    cfg_data,
	input  logic               start,
	input  htc_pkg::tri_in_t   triangle,
	input  logic               q_full,
	output logic               push,
	output htc_pkg::tri_word_t push_word
);

	htc_pkg::coord_t near_q;
	htc_pkg::coord_t far_q;

	function automatic logic vpass(htc_pkg::coord_t x, htc_pkg::coord_t y,
		htc_pkg::coord_t z, htc_pkg::coord_t w, htc_pkg::coord_t nr, htc_pkg::coord_t fr);
		logic signed [htc_pkg::DW-1:0] nw;
		logic ok;
		nw = -htc_pkg::DW'(w);
		ok = (w < nr) && (w > fr);
		if (htc_pkg::DW'(x) > nw || x < w) ok = 1'b0;
		if (htc_pkg::DW'(y) > nw || y < w) ok = 1'b0;
		if (htc_pkg::DW'(z) > nw || z < w) ok = 1'b0;
		return ok;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= '0;
			far_q <= {1'b1, {(htc_pkg::CW-1){1'b0}}};
		end else if (cfg_we) begin
			case (cfg_index)
				htc_pkg::REG_NEAR: near_q <= cfg_data;
				htc_pkg::REG_FAR: far_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign push = start && !q_full;

	always_comb begin
		push_word.a = '{triangle.a_x, triangle.a_y, triangle.a_z, triangle.a_w};
		push_word.b = '{triangle.b_x, triangle.b_y, triangle.b_z, triangle.b_w};
		push_word.c = '{triangle.c_x, triangle.c_y, triangle.c_z, triangle.c_w};
		push_word.pass =
			vpass(triangle.a_x, triangle.a_y, triangle.a_z, triangle.a_w, near_q, far_q) &&
			vpass(triangle.b_x, triangle.b_y, triangle.b_z, triangle.b_w, near_q, far_q) &&
			vpass(triangle.c_x, triangle.c_y, triangle.c_z, triangle.c_w, near_q, far_q);
	end

endmodule

>>> hdl/htc_queue.sv
// short triangle queue between front and back end
`timescale 1ns / 1ps
module htc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  htc_pkg::tri_word_t push_word,
	input  logic               pop,
	output htc_pkg::tri_word_t pop_word,
	output logic               full,
	output logic               empty
);

	localparam int AW = (htc_pkg::QDEPTH > 1) ? $clog2(htc_pkg::QDEPTH) : 1;
	localparam int NW = $clog2(htc_pkg::QDEPTH + 1);

	htc_pkg::tri_word_t mem_q [htc_pkg::QDEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [NW-1:0] cnt_q;

	assign full = (cnt_q == NW'(htc_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign pop_word = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(htc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(htc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> hdl/htc_div.sv
// restoring divider for the crossing weight, one quotient bit per cycle
`timescale 1ns / 1ps
module htc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [htc_pkg::DW-1:0]     num,
	input  logic [htc_pkg::FW-1:0]     den,
	output logic                       done,
	output logic [htc_pkg::QW-1:0]     quo
);

	localparam int CNTW = $clog2(htc_pkg::QW + 1);

	logic [htc_pkg::FW-1:0] rem_q;
	logic [htc_pkg::FW-1:0] den_q;
	logic [htc_pkg::QW-1:0] quo_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   nb_q;
	logic                   done_q;
	logic [htc_pkg::FW:0]   trial;
	logic                   ge;

	assign trial = {rem_q, nb_q};
	assign ge = (trial >= {1'b0, den_q});
	assign done = done_q;
	assign quo = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= htc_pkg::FW'(num >> 1);
			den_q <= den;
			nb_q <= num[0];
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? htc_pkg::FW'(trial - {1'b0, den_q}) : trial[htc_pkg::FW-1:0];
			quo_q <= {quo_q[htc_pkg::QW-2:0], ge};
			nb_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNTW'(1));
			if (start) cnt_q <= CNTW'(htc_pkg::QW);
			else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> hdl/htc_back.sv
// back end: six-plane polygon clipping over a ping-pong vertex memory
`timescale 1ns / 1ps
module htc_back #(
	parameter int MAX_POLY_VERTS = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  htc_pkg::tri_word_t q_word,
	output logic               pop,
	output logic               result_valid,
	output htc_pkg::vert_out_t result
);

	localparam int IW = $clog2(MAX_POLY_VERTS);
	localparam int CNW = $clog2(MAX_POLY_VERTS + 1);
	localparam int MD = 2 ** (IW + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_TRI   = 4'd2;
	localparam logic [3:0] S_PLANE = 4'd3;
	localparam logic [3:0] S_LATL  = 4'd4;
	localparam logic [3:0] S_RDC   = 4'd5;
	localparam logic [3:0] S_EVC   = 4'd6;
	localparam logic [3:0] S_ACT   = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_MULA  = 4'd9;
	localparam logic [3:0] S_MULB  = 4'd10;
	localparam logic [3:0] S_PUSHX = 4'd11;
	localparam logic [3:0] S_PUSHC = 4'd12;
	localparam logic [3:0] S_ADV   = 4'd13;
	localparam logic [3:0] S_EMIT  = 4'd14;
	localparam logic [3:0] S_EMPTY = 4'd15;

	logic [3:0]                 state_q;
	htc_pkg::tri_word_t         tri_q;
	logic [CNW-1:0]             j_q;
	logic [CNW-1:0]             n_q;
	logic [CNW-1:0]             count_q;
	logic [htc_pkg::PLW-1:0]    plane_q;
	logic                       bank_q;
	htc_pkg::vertex_t           l_q;
	htc_pkg::vertex_t           c_q;
	logic signed [htc_pkg::DW-1:0] dl_q;
	logic signed [htc_pkg::DW-1:0] dc_q;
	logic                       cin_q;
	logic                       lin_q;
	logic [htc_pkg::QW-1:0]     wt_q;
	logic [1:0]                 k_q;
	htc_pkg::coord_t            cross_q [4];
	logic [htc_pkg::PW-1:0]     prod_s1;
	logic                       neg_s1;
	htc_pkg::coord_t            a_s1;
	logic                       em_v_q;
	logic                       em_last_q;
	logic                       rv_q;
	htc_pkg::vert_out_t         res_q;

	htc_pkg::vertex_t           mem [MD];
	htc_pkg::vertex_t           rdata_q;
	logic [IW:0]                raddr;
	logic [IW:0]                waddr;
	htc_pkg::vertex_t           wdata;
	logic                       wen;

	logic signed [htc_pkg::DW-1:0] dc_now;
	logic signed [htc_pkg::DW-1:0] dl_now;
	logic signed [htc_pkg::FW-1:0] diff;
	logic [htc_pkg::DW-1:0]     div_num;
	logic [htc_pkg::FW-1:0]     div_den;
	logic                       div_start;
	logic                       div_done;
	logic [htc_pkg::QW-1:0]     div_quo;
	htc_pkg::coord_t            ma;
	htc_pkg::coord_t            mb;
	logic [htc_pkg::DW-1:0]     mag;
	logic [htc_pkg::PW-1:0]     rnd;
	logic [htc_pkg::DW-1:0]     off;
	htc_pkg::coord_t            mixed;
	logic                       room;

	function automatic logic signed [htc_pkg::DW-1:0] pdist(logic [htc_pkg::PLW-1:0] p,
		htc_pkg::vertex_t v);
		logic signed [htc_pkg::DW-1:0] c;
		logic signed [htc_pkg::DW-1:0] w;
		case (p[2:1])
			2'd0: c = htc_pkg::DW'(v.z);
			2'd1: c = htc_pkg::DW'(v.y);
			default: c = htc_pkg::DW'(v.x);
		endcase
		w = htc_pkg::DW'(v.w);
		return p[0] ? w - c : w + c;
	endfunction

	function automatic htc_pkg::vertex_t tri_vert(htc_pkg::tri_word_t t, logic [1:0] i);
		htc_pkg::vertex_t v;
		case (i)
			2'd0: v = t.a;
			2'd1: v = t.b;
			default: v = t.c;
		endcase
		return v;
	endfunction

	htc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign pop = (state_q == S_IDLE) && !q_empty;
	assign room = (n_q < CNW'(MAX_POLY_VERTS));

	assign dc_now = pdist(plane_q, rdata_q);
	assign dl_now = pdist(plane_q, l_q);
	assign diff = htc_pkg::FW'(dl_q) - htc_pkg::FW'(dc_q);
	assign div_num = dl_q[htc_pkg::DW-1] ? htc_pkg::DW'(-dl_q) : htc_pkg::DW'(dl_q);
	assign div_den = diff[htc_pkg::FW-1] ? htc_pkg::FW'(-diff) : htc_pkg::FW'(diff);
	assign div_start = (state_q == S_ACT) && (cin_q != lin_q);

	// crossing point, one coordinate per pass through the multiplier
	assign ma = htc_pkg::vcoord(l_q, k_q);
	assign mb = htc_pkg::vcoord(c_q, k_q);
	assign mag = (mb >= ma) ? htc_pkg::DW'(htc_pkg::DW'(mb) - htc_pkg::DW'(ma))
		: htc_pkg::DW'(htc_pkg::DW'(ma) - htc_pkg::DW'(mb));
	assign rnd = prod_s1 + (htc_pkg::PW'(1) << (htc_pkg::WF - 1));
	assign off = rnd[htc_pkg::WF +: htc_pkg::DW];
	assign mixed = neg_s1 ? htc_pkg::CW'(htc_pkg::DW'(a_s1) - off)
		: htc_pkg::CW'(htc_pkg::DW'(a_s1) + off);

	always_comb begin
		raddr = {bank_q, j_q[IW-1:0]};
		if (state_q == S_PLANE) raddr = {bank_q, IW'(count_q - 1'b1)};
		waddr = {~bank_q, n_q[IW-1:0]};
		wdata = c_q;
		wen = 1'b0;
		case (state_q)
			S_LOAD: begin
				waddr = {1'b0, j_q[IW-1:0]};
				wdata = tri_vert(tri_q, j_q[1:0]);
				wen = 1'b1;
			end
			S_PUSHX: begin
				wdata = '{cross_q[0], cross_q[1], cross_q[2], cross_q[3]};
				wen = room;
			end
			S_PUSHC: begin
				wen = room;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (pop) tri_q <= q_word;
		if (state_q == S_LATL) l_q <= rdata_q;
		if (state_q == S_ADV) l_q <= c_q;
		if (state_q == S_EVC) begin
			c_q <= rdata_q;
			dc_q <= dc_now;
			dl_q <= dl_now;
			cin_q <= (dc_now <= 0);
			lin_q <= (dl_now <= 0);
		end
		if (state_q == S_DIV && div_done) wt_q <= (div_den == '0) ? '0 : div_quo;
		if (state_q == S_MULA) begin
			prod_s1 <= htc_pkg::PW'(mag) * htc_pkg::PW'(wt_q);
			neg_s1 <= (mb < ma);
			a_s1 <= ma;
		end
		if (state_q == S_MULB) cross_q[k_q] <= mixed;
		if (em_v_q) res_q <= htc_pkg::to_out(rdata_q, em_last_q);
		else if (state_q == S_TRI) res_q <= htc_pkg::to_out(tri_vert(tri_q, j_q[1:0]),
			j_q == CNW'(2));
		else if (state_q == S_EMPTY) res_q <= '{'0, '0, '0, '0, 1'b1, 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			n_q <= '0;
			count_q <= '0;
			plane_q <= '0;
			bank_q <= 1'b0;
			k_q <= '0;
			em_v_q <= 1'b0;
			em_last_q <= 1'b0;
			rv_q <= 1'b0;
		end else begin
			em_v_q <= 1'b0;
			rv_q <= em_v_q || (state_q == S_TRI) || (state_q == S_EMPTY);
			case (state_q)
				S_IDLE: begin
					j_q <= '0;
					if (!q_empty) state_q <= q_word.pass ? S_TRI : S_LOAD;
				end
				S_TRI: begin
					j_q <= j_q + 1'b1;
					if (j_q == CNW'(2)) state_q <= S_IDLE;
				end
				S_LOAD: begin
					j_q <= j_q + 1'b1;
					if (j_q == CNW'(2)) begin
						bank_q <= 1'b0;
						count_q <= CNW'(3);
						plane_q <= '0;
						state_q <= S_PLANE;
					end
				end
				S_PLANE: begin
					j_q <= '0;
					n_q <= '0;
					if (count_q == '0) state_q <= S_EMPTY;
					else if (plane_q == htc_pkg::PLW'(htc_pkg::NUM_PLANES)) state_q <= S_EMIT;
					else state_q <= S_LATL;
				end
				S_LATL: state_q <= S_RDC;
				S_RDC: state_q <= S_EVC;
				S_EVC: state_q <= S_ACT;
				S_ACT: begin
					k_q <= '0;
					if (cin_q != lin_q) state_q <= S_DIV;
					else if (cin_q) state_q <= S_PUSHC;
					else state_q <= S_ADV;
				end
				S_DIV: if (div_done) state_q <= S_MULA;
				S_MULA: state_q <= S_MULB;
				S_MULB: begin
					k_q <= k_q + 1'b1;
					state_q <= (k_q == 2'd3) ? S_PUSHX : S_MULA;
				end
				S_PUSHX: begin
					if (room) n_q <= n_q + 1'b1;
					state_q <= cin_q ? S_PUSHC : S_ADV;
				end
				S_PUSHC: begin
					if (room) n_q <= n_q + 1'b1;
					state_q <= S_ADV;
				end
				S_ADV: begin
					if (j_q == count_q - 1'b1) begin
						count_q <= n_q;
						bank_q <= ~bank_q;
						plane_q <= plane_q + 1'b1;
						state_q <= S_PLANE;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_RDC;
					end
				end
				S_EMIT: begin
					em_v_q <= 1'b1;
					em_last_q <= (j_q == count_q - 1'b1);
					j_q <= j_q + 1'b1;
					if (j_q == count_q - 1'b1) state_q <= S_IDLE;
				end
				S_EMPTY: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = rv_q;
	assign result = res_q;

endmodule

>>> hdl/homogeneous_triangle_clipper.sv
// top level of the homogeneous triangle clipper
//
// port group    direction  timing
// start/triangle  in       word taken when start is high and busy is low
// cfg_*           in       register written on any edge with cfg_we high
// result          out      one word per cycle marked by result_valid, no stall
//
// a triangle that passes the view-volume test gives its three words in
// consecutive cycles once the back end takes it. a clipped triangle loads
// its three vertices, then walks six planes: it latches the last vertex per
// plane, reads, tests and advances per vertex, pushes each kept vertex, and
// runs the bit-serial weight divider and the shared multiplier per crossing;
// the words then follow one per cycle. a two-word queue lets a new triangle be
// taken while the back end works. reset clears the limits to their defaults.
`timescale 1ns / 1ps
module homogeneous_triangle_clipper #(
	parameter int MAX_POLY_VERTS = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  htc_pkg::coord_t    cfg_data,
	input  logic               start,
	input  htc_pkg::tri_in_t   triangle,
	output logic               busy,
	output logic               result_valid,
	output htc_pkg::vert_out_t result
);

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	htc_pkg::tri_word_t q_in;
	htc_pkg::tri_word_t q_out;

	htc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.triangle  (triangle),
		.q_full    (q_full),
		.push      (q_push),
		.push_word (q_in)
	);

	htc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in),
		.pop       (q_pop),
		.pop_word  (q_out),
		.full      (q_full),
		.empty     (q_empty)
	);

	htc_back #(
		.MAX_POLY_VERTS (MAX_POLY_VERTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_word       (q_out),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result       (result)
	);

	assign busy = q_full;

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_empty |-> result.is_last && result.out_x == '0 &&
		result.out_y == '0 && result.out_z == '0 && result.out_w == '0)
		else $error("empty word carries data");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a word taken");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_last |=> result_valid)
		else $error("gap inside a polygon");

endmodule
